// File: src/sbrp_pkg.sv
package sbrp_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 2048;

    localparam logic [15:0] RESP_TYPE    = 16'h0101;
    localparam logic [31:0] STUN_COOKIE  = 32'h2112A442;
    localparam logic [7:0]  FAMILY_IPV4  = 8'h01;
    localparam int          HEADER_BYTES = 20;
    localparam int          ID_BYTES     = 12;

    // Verdict codes carried on the result channel.
    localparam logic [3:0] V_OK      = 4'd0;
    localparam logic [3:0] V_TYPE    = 4'd1;
    localparam logic [3:0] V_COOKIE  = 4'd2;
    localparam logic [3:0] V_TRANS   = 4'd3;
    localparam logic [3:0] V_EMPTY   = 4'd4;
    localparam logic [3:0] V_SHORT   = 4'd5;
    localparam logic [3:0] V_NOADDR  = 4'd6;
    localparam logic [3:0] V_BADATTR = 4'd7;
    localparam logic [3:0] V_TRUNC   = 4'd8;

    typedef struct packed {
        logic [3:0]  verdict;
        logic [15:0] mapped_port;
        logic [31:0] mapped_ip;
    } result_t;

endpackage

// File: src/sbrp_parser.sv
module sbrp_parser #(
    parameter int MAX_PACKET_BYTES = sbrp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_go,
    input  logic [7:0]          data_byte,
    input  logic                packet_last,
    input  logic [63:0]         tid_high,
    input  logic [31:0]         tid_low,
    output logic                res_valid,
    output sbrp_pkg::result_t   res
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_ID_FIRST = POS_W'(sbrp_pkg::HEADER_BYTES
                                                       - sbrp_pkg::ID_BYTES);
    localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(sbrp_pkg::HEADER_BYTES - 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ATTR   = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_ADDR   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [2:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      len_reg, len_next;
    logic [31:0]      acc_reg, acc_next;
    logic [15:0]      atype_reg, atype_next;
    logic [15:0]      skip_reg, skip_next;
    logic [15:0]      port_reg, port_next;
    logic             given_reg, given_next;

    logic [95:0]  tid_all;
    logic [3:0]   id_idx;
    logic [7:0]   exp_byte;
    logic [15:0]  skip_dec;
    logic [15:0]  asize;
    logic [17:0]  attr_total;
    logic [2:0]   addr_idx;
    logic         parse_en;
    logic         hit;
    logic [3:0]   code;

    assign tid_all  = {tid_high, tid_low};
    assign id_idx   = 4'(pos_reg - POS_ID_FIRST);
    assign skip_dec = skip_reg - 16'd1;
    assign asize    = acc_next[15:0];
    assign attr_total = 18'(asize) + 18'd4;
    assign addr_idx = 3'd0 - skip_reg[2:0];

    // Expected transaction ID byte for the current header position.
    always_comb begin
        exp_byte = 8'h00;
        for (int k = 0; k < sbrp_pkg::ID_BYTES; k++) begin
            if (id_idx == 4'(k)) begin
                exp_byte = tid_all[95 - 8*k -: 8];
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        atype_next = atype_reg;
        skip_next  = skip_reg;
        port_next  = port_reg;
        given_next = given_reg;
        hit        = 1'b0;
        code       = sbrp_pkg::V_OK;
        parse_en   = !given_reg && (pos_reg < POS_MAX);

        if (parse_en) begin
            acc_next = {acc_reg[23:0], data_byte};
            case (phase_reg)
                PH_HEADER: begin
                    if (pos_reg == POS_W'(1) && acc_next[15:0] != sbrp_pkg::RESP_TYPE) begin
                        hit  = 1'b1;
                        code = sbrp_pkg::V_TYPE;
                    end
                    if (pos_reg == POS_W'(3)) begin
                        len_next = acc_next[15:0];
                    end
                    if (pos_reg == POS_W'(7) && acc_next != sbrp_pkg::STUN_COOKIE) begin
                        hit  = 1'b1;
                        code = sbrp_pkg::V_COOKIE;
                    end
                    if (pos_reg >= POS_ID_FIRST && pos_reg <= POS_HDR_LAST
                        && data_byte != exp_byte) begin
                        hit  = 1'b1;
                        code = sbrp_pkg::V_TRANS;
                    end else if (pos_reg == POS_HDR_LAST) begin
                        if (len_reg == 16'd0) begin
                            hit  = 1'b1;
                            code = sbrp_pkg::V_EMPTY;
                        end else if (len_reg < 16'd4) begin
                            hit  = 1'b1;
                            code = sbrp_pkg::V_SHORT;
                        end else begin
                            phase_next = PH_ATTR;
                            skip_next  = 16'd4;
                        end
                    end
                end
                PH_ATTR: begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd2) begin
                        atype_next = acc_next[15:0];
                    end
                    if (skip_dec == 16'd0) begin
                        if (atype_reg == 16'd0 || atype_reg == 16'd1) begin
                            if (asize != 16'd8) begin
                                hit  = 1'b1;
                                code = sbrp_pkg::V_BADATTR;
                            end else begin
                                phase_next = PH_ADDR;
                                skip_next  = 16'd8;
                            end
                        end else if (18'(len_reg) < attr_total + 18'd4) begin
                            // Not even a further attribute header would fit.
                            hit  = 1'b1;
                            code = sbrp_pkg::V_NOADDR;
                        end else begin
                            len_next = len_reg - attr_total[15:0];
                            if (asize == 16'd0) begin
                                skip_next = 16'd4;
                            end else begin
                                phase_next = PH_SKIP;
                                skip_next  = asize;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        phase_next = PH_ATTR;
                        skip_next  = 16'd4;
                    end
                end
                PH_ADDR: begin
                    skip_next = skip_dec;
                    if (addr_idx == 3'd1 && data_byte != sbrp_pkg::FAMILY_IPV4) begin
                        hit  = 1'b1;
                        code = sbrp_pkg::V_BADATTR;
                    end
                    if (addr_idx == 3'd3) begin
                        port_next = acc_next[15:0];
                    end
                    if (addr_idx == 3'd7) begin
                        hit  = 1'b1;
                        code = sbrp_pkg::V_OK;
                    end
                end
                default: begin
                end
            endcase
        end

        if (pos_reg < POS_MAX) begin
            pos_next = pos_reg + POS_W'(1);
        end

        if (!hit && packet_last && !given_reg) begin
            hit  = 1'b1;
            code = sbrp_pkg::V_TRUNC;
        end

        if (hit) begin
            given_next = 1'b1;
            phase_next = PH_DONE;
        end

        res_valid       = hit;
        res.verdict     = code;
        res.mapped_port = (code == sbrp_pkg::V_OK) ? port_next : 16'd0;
        res.mapped_ip   = (code == sbrp_pkg::V_OK) ? acc_next : 32'd0;

        // The last byte of a packet rearms the parser for the next one.
        if (packet_last) begin
            phase_next = PH_HEADER;
            pos_next   = '0;
            len_next   = 16'd0;
            acc_next   = 32'd0;
            atype_next = 16'd0;
            skip_next  = 16'd0;
            port_next  = 16'd0;
            given_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            len_reg   <= 16'd0;
            acc_reg   <= 32'd0;
            atype_reg <= 16'd0;
            skip_reg  <= 16'd0;
            port_reg  <= 16'd0;
            given_reg <= 1'b0;
        end else if (item_go) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            atype_reg <= atype_next;
            skip_reg  <= skip_next;
            port_reg  <= port_next;
            given_reg <= given_next;
        end
    end

endmodule

// File: src/stun_binding_response_parser.sv
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// input     | in        | s_valid / s_ready  | s_data_byte, s_packet_last
// result    | out       | m_valid / m_ready  | m_verdict, m_mapped_port, m_mapped_ip
// config    | in        | APB psel / penable | paddr, pwdata, prdata (64-bit data)
//
// One byte item can be taken in every cycle unless a held byte stalls; its verdict, if it
// decides one, is offered on m_valid from the result register (parse logic between the two
// registers). The parse state moves with each byte, so the rate is one item per cycle.
// Synchronous active-low reset clears all control state and both ID registers.
// A byte that decides a verdict waits in the input register while the result
// register is full and not being drained; other bytes flow on regardless.
module stun_binding_response_parser #(
    parameter int MAX_PACKET_BYTES = sbrp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_packet_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_verdict,
    output logic [15:0] m_mapped_port,
    output logic [31:0] m_mapped_ip,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] tid_high_reg;
    logic [31:0] tid_low_reg;

    logic        in_vld_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        out_vld_reg;
    sbrp_pkg::result_t out_res_reg;

    logic              in_go;
    logic              res_valid_any;
    logic              res_valid;
    sbrp_pkg::result_t res;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[3] ? {32'd0, tid_low_reg} : tid_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tid_high_reg <= 64'd0;
            tid_low_reg  <= 32'd0;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                tid_low_reg <= pwdata[31:0];
            end else begin
                tid_high_reg <= pwdata;
            end
        end
    end

    // A held byte moves on unless it yields a result that has nowhere to go.
    assign in_go   = in_vld_reg && (!res_valid_any || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || in_go;

    sbrp_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_go     (in_go),
        .data_byte   (in_data_reg),
        .packet_last (in_last_reg),
        .tid_high    (tid_high_reg),
        .tid_low     (tid_low_reg),
        .res_valid   (res_valid_any),
        .res         (res)
    );

    assign res_valid = res_valid_any && in_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (res_valid) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_packet_last;
        end
        if (res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_verdict     = out_res_reg.verdict;
    assign m_mapped_port = out_res_reg.mapped_port;
    assign m_mapped_ip   = out_res_reg.mapped_ip;

    // A new verdict never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_valid && out_vld_reg && !m_ready))
        else $error("verdict overwrote a pending result item");

    // Address fields are zero unless the verdict is a success.
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_verdict != sbrp_pkg::V_OK) |->
            (m_mapped_port == 16'd0 && m_mapped_ip == 32'd0))
        else $error("address fields set on a failing verdict");

    // Verdict codes stay within the defined set.
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_verdict <= sbrp_pkg::V_TRUNC))
        else $error("undefined verdict code");

    // A byte held back by a full result register stays held until it drains.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !in_go) |=> in_vld_reg)
        else $error("held byte lost while stalled");

endmodule
